// File: rtl/core/ianc_pkg.sv
`default_nettype none
package ianc_pkg;

   localparam int DIGIT_COUNT = 10;
   localparam int NUM_W       = 34;
   localparam int WT_W        = 4 * DIGIT_COUNT;

   // Largest valid ten-digit number plus one
   localparam logic [NUM_W-1:0] TEN_POW_TEN = 34'd10000000000;
   localparam logic [WT_W-1:0]  WT_RESET    = 40'h6379A58421;

   // One item moving down the digit chain
   typedef struct packed {
      logic                  vld;
      logic                  over;   // number above the ten-digit range
      logic [NUM_W-1:0]      rem;    // part of the number not yet split off
      logic [WT_W-1:0]       bcd;    // decimal digits, least significant in low nibble
      logic [3:0]            dmod;   // digit sum mod 11
      logic [3:0]            wmod;   // weighted digit sum mod 11
   } ianc_lane_type;

   // Power of ten for a digit position
   function automatic logic [NUM_W-1:0] pow10(input logic [3:0] pos);
      logic [NUM_W-1:0] p;
      case (pos)
         4'd0:    p = 34'd1;
         4'd1:    p = 34'd10;
         4'd2:    p = 34'd100;
         4'd3:    p = 34'd1000;
         4'd4:    p = 34'd10000;
         4'd5:    p = 34'd100000;
         4'd6:    p = 34'd1000000;
         4'd7:    p = 34'd10000000;
         4'd8:    p = 34'd100000000;
         4'd9:    p = 34'd1000000000;
         default: p = 34'd0;
      endcase
      return p;
   endfunction

   // Remainder mod 11 for values below 176, by restoring subtraction
   function automatic logic [3:0] mod11(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (r >= 8'd88) r = r - 8'd88;
      if (r >= 8'd44) r = r - 8'd44;
      if (r >= 8'd22) r = r - 8'd22;
      if (r >= 8'd11) r = r - 8'd11;
      return r[3:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ianc_cell.sv
`default_nettype none
module ianc_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [3:0]             pos,
   input  wire [3:0]             weight,
   input  ianc_pkg::ianc_lane_type lane_in,
   output ianc_pkg::ianc_lane_type lane_out
);
   import ianc_pkg::*;

   ianc_lane_type    lane_ff;
   ianc_lane_type    lane_in_nxt;
   logic [NUM_W-1:0] pow;
   logic [NUM_W-1:0] thr;
   logic [NUM_W-1:0] sub;
   logic [3:0]       digit;
   logic [7:0]       prod;

   // Split off the digit at this position: largest d with d*10^pos <= rem
   always_comb begin
      pow   = pow10(pos);
      digit = '0;
      sub   = '0;
      thr   = '0;
      for (int d = 1; d <= 9; d++) begin
         thr = NUM_W'(pow * NUM_W'(d));
         if (lane_in.rem >= thr) begin
            digit = 4'(d);
            sub   = thr;
         end
      end
      prod = {4'b0, digit} * {4'b0, weight};

      lane_in_nxt      = lane_in;
      lane_in_nxt.rem  = lane_in.rem - sub;
      for (int n = 0; n < DIGIT_COUNT; n++) begin
         if (4'(n) == pos) lane_in_nxt.bcd[4*n +: 4] = digit;
      end
      lane_in_nxt.dmod = mod11({4'b0, lane_in.dmod} + {4'b0, digit});
      lane_in_nxt.wmod = mod11({4'b0, lane_in.wmod} + prod);
   end

   // Valid is control, the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.vld <= 1'b0;
      end else begin
         lane_ff.vld <= lane_in_nxt.vld;
      end
      lane_ff.over <= lane_in_nxt.over;
      lane_ff.rem  <= lane_in_nxt.rem;
      lane_ff.bcd  <= lane_in_nxt.bcd;
      lane_ff.dmod <= lane_in_nxt.dmod;
      lane_ff.wmod <= lane_in_nxt.wmod;
   end

   assign lane_out = lane_ff;

endmodule
`default_nettype wire

// File: rtl/core/ianc_verdict.sv
`default_nettype none
module ianc_verdict (
   input  wire                     clock,
   input  wire                     reset,
   input  ianc_pkg::ianc_lane_type lane_in,
   output logic                    rsp_valid,
   output logic                    rsp_identity_ok,
   output logic                    rsp_account_ok,
   output logic                    rsp_both_ok
);
   import ianc_pkg::*;

   localparam logic [3:0] MON_FEB = 4'd2;
   localparam logic [3:0] MON_APR = 4'd4;
   localparam logic [3:0] MON_JUN = 4'd6;
   localparam logic [3:0] MON_SEP = 4'd9;
   localparam logic [3:0] MON_NOV = 4'd11;

   logic [6:0] yy;
   logic [6:0] mraw;
   logic [6:0] dd;
   logic [3:0] mm;
   logic [4:0] mlen;
   logic       leap;
   logic       id_ok;
   logic       acc_ok;
   logic       valid_ff;
   logic       id_ff;
   logic       acc_ff;

   always_comb begin
      yy   = 7'({lane_in.bcd[39:36], 3'b0}) + 7'({lane_in.bcd[39:36], 1'b0})
             + 7'(lane_in.bcd[35:32]);
      mraw = 7'({lane_in.bcd[31:28], 3'b0}) + 7'({lane_in.bcd[31:28], 1'b0})
             + 7'(lane_in.bcd[27:24]);
      dd   = 7'({lane_in.bcd[23:20], 3'b0}) + 7'({lane_in.bcd[23:20], 1'b0})
             + 7'(lane_in.bcd[19:16]);

      // Month: plain or offset by 50
      mm = '0;
      if (mraw inside {[7'd1:7'd12]}) begin
         mm = mraw[3:0];
      end else if (mraw inside {[7'd51:7'd62]}) begin
         mm = 4'(mraw - 7'd50);
      end

      // 1900 and 2000 are both multiples of 4; the only century year reachable
      // is 2000 (yy of 0), a leap year, so the two-digit year decides alone
      leap = (yy[1:0] == 2'b00);

      case (mm)
         MON_APR, MON_JUN, MON_SEP, MON_NOV: mlen = 5'd30;
         MON_FEB:                            mlen = leap ? 5'd29 : 5'd28;
         default:                            mlen = 5'd31;
      endcase

      id_ok  = !lane_in.over && (mm != 4'd0) && (dd != 7'd0) && (dd <= 7'(mlen))
               && (lane_in.dmod == 4'd0);
      acc_ok = (lane_in.wmod == 4'd0);
   end

   // Output register, one strobe per item
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane_in.vld;
      end
      id_ff  <= id_ok;
      acc_ff <= acc_ok;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_identity_ok = id_ff;
   assign rsp_account_ok  = acc_ff;
   assign rsp_both_ok     = id_ff & acc_ff;

endmodule
`default_nettype wire

// File: rtl/core/id_and_account_number_checker.sv
`default_nettype none
// An item passes through the input register, ten digit cells and the output register
// before its result strobe reaches the ports.
// Throughput: one item every cycle; busy is never raised.
// Reset clears the weight register to 0x6379A58421 and empties the pipeline.
// Results cannot be stalled by the receiver.
module id_and_account_number_checker (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire [ianc_pkg::NUM_W-1:0]   req_number_value,
   input  wire                         csr_wr_en,
   input  wire [ianc_pkg::WT_W-1:0]    csr_wr_data,
   output logic                        rsp_valid,
   output logic                        rsp_identity_ok,
   output logic                        rsp_account_ok,
   output logic                        rsp_both_ok
);
   import ianc_pkg::*;

   logic [WT_W-1:0] weight_ff;
   ianc_lane_type   head_in;
   ianc_lane_type   head_ff;
   ianc_lane_type   lane [0:DIGIT_COUNT];

   assign busy = 1'b0;

   // Weight register
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WT_RESET;
      end else if (csr_wr_en) begin
         weight_ff <= csr_wr_data;
      end
   end

   // Entry stage: strip the range overflow, keep the low ten digits
   always_comb begin
      head_in      = '0;
      head_in.vld  = start & ~busy;
      head_in.over = (req_number_value >= TEN_POW_TEN);
      head_in.rem  = head_in.over ? (req_number_value - TEN_POW_TEN) : req_number_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.vld <= 1'b0;
      end else begin
         head_ff.vld <= head_in.vld;
      end
      head_ff.over <= head_in.over;
      head_ff.rem  <= head_in.rem;
      head_ff.bcd  <= head_in.bcd;
      head_ff.dmod <= head_in.dmod;
      head_ff.wmod <= head_in.wmod;
   end

   assign lane[0] = head_ff;

   // Digit chain, most significant digit first
   for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
      ianc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .pos      (4'(DIGIT_COUNT - 1 - i)),
         .weight   (weight_ff[4*(DIGIT_COUNT-1-i) +: 4]),
         .lane_in  (lane[i]),
         .lane_out (lane[i+1])
      );
   end

   ianc_verdict u_verdict (
      .clock           (clock),
      .reset           (reset),
      .lane_in         (lane[DIGIT_COUNT]),
      .rsp_valid       (rsp_valid),
      .rsp_identity_ok (rsp_identity_ok),
      .rsp_account_ok  (rsp_account_ok),
      .rsp_both_ok     (rsp_both_ok)
   );

endmodule
`default_nettype wire

// File: tb/id_and_account_number_checker_tb.sv
`timescale 1ns / 1ps
module id_and_account_number_checker_tb;
   import ianc_pkg::*;

   localparam int PIPE_LATENCY  = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int N_PHASES      = 6;
   localparam int ITEMS_PER_SET = 313;
   localparam int N_DIRECTED    = 24;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic identity_ok;
      logic account_ok;
      logic both_ok;
   } verdict_type;

   // One directed item; the verdict is used only where typed is set
   typedef struct packed {
      logic [NUM_W-1:0] number;
      bit               typed;
      verdict_type      verdict;   // identity, account, both
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   logic [NUM_W-1:0] req_number_value;
   logic             csr_wr_en;
   logic [WT_W-1:0]  csr_wr_data;
   logic             rsp_valid;
   logic             rsp_identity_ok;
   logic             rsp_account_ok;
   logic             rsp_both_ok;

   // Testbench copy of the weight register
   logic [WT_W-1:0] weight_copy;
   verdict_type     verdict_q[$];

   int cycle_count    = 0;
   int items_sent     = 0;
   int verdicts_seen  = 0;
   int mismatch_count = 0;
   int identity_pass  = 0;
   int account_pass   = 0;
   int burst_left     = 0;

   // Directed items, all under the reset weights
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{34'd0,           1'b1, 3'b010},   // all digits zero: no month
      '{34'd10000000000, 1'b1, 3'b010},   // just over range, low digits zero
      '{34'd9999999999,  1'b0, 3'b000},   // largest ten-digit number
      '{34'd17179869183, 1'b0, 3'b000},   // largest field value
      '{34'h2AAAAAAAA,   1'b0, 3'b000},
      '{34'h155555555,   1'b0, 3'b000},
      '{34'd1010009,     1'b0, 3'b000},   // 2000-01-01
      '{34'd2290009,     1'b0, 3'b000},   // Feb 29 in 2000, a 400-year leap
      '{34'd5602290009,  1'b0, 3'b000},   // Feb 29 in 1956
      '{34'd5402280001,  1'b0, 3'b000},   // Feb 28 in 1954
      '{34'd5402290002,  1'b0, 3'b000},   // Feb 29 in 1954, not leap
      '{34'd5202290002,  1'b0, 3'b000},   // Feb 29 in 2052
      '{34'd5302290001,  1'b0, 3'b000},   // Feb 29 in 2053, not leap
      '{34'd51010004,    1'b0, 3'b000},   // month 51
      '{34'd62310019,    1'b0, 3'b000},   // month 62, day 31
      '{34'd13010006,    1'b0, 3'b000},   // month 13
      '{34'd50010005,    1'b0, 3'b000},   // month 50
      '{34'd63010001,    1'b0, 3'b000},   // month 63
      '{34'd1000019,     1'b0, 3'b000},   // day 0
      '{34'd1320005,     1'b0, 3'b000},   // Jan 32
      '{34'd4310003,     1'b0, 3'b000},   // Apr 31
      '{34'd4300004,     1'b0, 3'b000},   // Apr 30
      '{34'd1010000,     1'b0, 3'b000},   // good date, bad digit sum
      '{34'd9912310008,  1'b0, 3'b000}    // 1999-12-31
   };

   id_and_account_number_checker dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_number_value (req_number_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_identity_ok  (rsp_identity_ok),
      .rsp_account_ok   (rsp_account_ok),
      .rsp_both_ok      (rsp_both_ok)
   );

   always #5 clock = ~clock;

   // Days in a month, Gregorian leap rule
   function automatic int month_days(input int year, input int month);
      if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
      if (month == 2) begin
         if ((year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0))) return 29;
         return 28;
      end
      return 31;
   endfunction

   // Expected verdicts for one number under the given weights
   function automatic verdict_type predict_verdict(input logic [NUM_W-1:0] num,
                                                   input logic [WT_W-1:0] wts);
      longint unsigned rest;
      int              dig[10];
      int              k, dsum, wsum, yy, mraw, dd, mm, year;
      verdict_type     v;
      rest = num;
      dsum = 0;
      wsum = 0;
      for (k = 0; k < 10; k++) begin
         dig[k] = int'(rest % 10);
         rest   = rest / 10;
         dsum  += dig[k];
         wsum  += dig[k] * int'(wts[4*k +: 4]);
      end
      v.account_ok = (wsum % 11 == 0);
      if (rest != 0) begin
         v.identity_ok = 1'b0;
      end else begin
         yy   = dig[9] * 10 + dig[8];
         mraw = dig[7] * 10 + dig[6];
         dd   = dig[5] * 10 + dig[4];
         if (mraw >= 1 && mraw <= 12) mm = mraw;
         else if (mraw >= 51 && mraw <= 62) mm = mraw - 50;
         else mm = 0;
         year = (yy >= 54) ? 1900 + yy : 2000 + yy;
         if (mm == 0) v.identity_ok = 1'b0;
         else if (dd < 1 || dd > month_days(year, mm)) v.identity_ok = 1'b0;
         else v.identity_ok = (dsum % 11 == 0);
      end
      v.both_ok = v.identity_ok & v.account_ok;
      return v;
   endfunction

   // Random number: mostly well-formed identity numbers, plus noise and broken dates
   function automatic logic [NUM_W-1:0] random_number();
      int              kind, yy, mraw, mm, dd, tail, year, s, need, k;
      bit              dated;
      longint unsigned v, t;
      kind  = $urandom_range(9, 0);
      dated = 1'b0;
      v     = 0;
      yy    = $urandom_range(99, 0);
      year  = (yy >= 54) ? 1900 + yy : 2000 + yy;
      mm    = $urandom_range(12, 1);
      mraw  = $urandom_range(1, 0) ? mm + 50 : mm;
      tail  = $urandom_range(9999, 0);
      dd    = $urandom_range(3, 0) == 0 ? month_days(year, mm)
                                        : $urandom_range(month_days(year, mm), 1);
      case (kind)
         0, 1, 2, 3, 4: dated = 1'b1;
         5, 6: v = {$urandom_range(3, 0), $urandom};
         7: begin
            case ($urandom_range(2, 0))
               0: v = 64'd10000000000 + $urandom_range(255, 0);
               1: v = 64'd17179869183 - $urandom_range(255, 0);
               default: v = 64'd9999999999 - $urandom_range(255, 0);
            endcase
         end
         8: v = {$urandom, $urandom} % 64'd10000000000;
         default: begin
            // broken date: bad month or day just outside the month
            dated = 1'b1;
            case ($urandom_range(5, 0))
               0: mraw = 0;
               1: mraw = 13;
               2: mraw = 50;
               3: mraw = 63;
               4: dd = $urandom_range(1, 0) ? 0 : month_days(year, mm) + 1;
               default: mraw = $urandom_range(99, 0);
            endcase
         end
      endcase
      if (dated) begin
         v = longint'(yy) * 100000000 + longint'(mraw) * 1000000
           + longint'(dd) * 10000 + longint'(tail);
         // mostly fix the last digit so the digit sum is 0 mod 11
         if ($urandom_range(4, 0) != 0) begin
            s = 0;
            t = v / 10;
            for (k = 0; k < 9; k++) begin
               s += int'(t % 10);
               t  = t / 10;
            end
            need = (11 - s % 11) % 11;
            if (need <= 9) v = v - v % 10 + need;
         end
      end
      return v[NUM_W-1:0];
   endfunction

   // Send one item in bursts with random gaps; record its verdict when accepted
   task automatic send_number(input logic [NUM_W-1:0] num, input bit typed,
                              input verdict_type typed_verdict);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
         if (gap > 0) begin
            start            <= 1'b0;
            req_number_value <= NUM_W'({$urandom_range(3, 0), $urandom});
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start            <= 1'b1;
      req_number_value <= num;
      do @(posedge clock); while (busy);
      verdict_q.push_back(typed ? typed_verdict : predict_verdict(num, weight_copy));
      items_sent++;
   endtask

   // Load new weights once the pipeline has drained
   task automatic load_weights(input logic [WT_W-1:0] wts);
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= wts;
      @(posedge clock);
      weight_copy = wts;
      csr_wr_en   <= 1'b0;
      burst_left  = 0;
   endtask

   // Result checker
   always @(posedge clock) begin
      verdict_type got, want;
      got = '{rsp_identity_ok, rsp_account_ok, rsp_both_ok};
      if (!reset && rsp_valid) begin
         verdicts_seen++;
         identity_pass += got.identity_ok;
         account_pass  += got.account_ok;
         if (verdict_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected item result %0d: identity %0b account %0b both %0b",
                        verdicts_seen, got.identity_ok, got.account_ok, got.both_ok);
         end else begin
            want = verdict_q.pop_front();
            if (got.identity_ok !== want.identity_ok || got.account_ok !== want.account_ok
                || got.both_ok !== want.both_ok) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"item result %0d: identity exp %0b got %0b, ",
                            "account exp %0b got %0b, both exp %0b got %0b"},
                           verdicts_seen, want.identity_ok, got.identity_ok,
                           want.account_ok, got.account_ok, want.both_ok, got.both_ok);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [WT_W-1:0] set_wts [N_PHASES];
      int              p, n;
      reset            = 1'b1;
      start            = 1'b0;
      req_number_value = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      weight_copy      = WT_RESET;
      // weight settings: reset value, all zero, all ones, two random, reset again
      set_wts[0] = WT_RESET;
      set_wts[1] = '0;
      set_wts[2] = '1;
      set_wts[3] = WT_W'({$urandom_range(255, 0), $urandom});
      set_wts[4] = WT_W'({$urandom_range(255, 0), $urandom});
      set_wts[5] = WT_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed items
      for (n = 0; n < N_DIRECTED; n++)
         send_number(directed_rows[n].number, directed_rows[n].typed,
                     directed_rows[n].verdict);

      // random items under each weight setting
      for (p = 0; p < N_PHASES; p++) begin
         if (p > 0) load_weights(set_wts[p]);
         for (n = 0; n < ITEMS_PER_SET; n++)
            send_number(random_number(), 1'b0, '0);
      end
      start <= 1'b0;

      while (verdict_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("Sent %0d items under %0d weight settings, %0d results checked, %0d mismatches.",
               items_sent, N_PHASES, verdicts_seen, mismatch_count);
      $display("Identity check passed %0d times, account check %0d times.",
               identity_pass, account_pass);
      if (mismatch_count == 0 && verdict_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: id_and_account_number_checker.f
rtl/core/ianc_pkg.sv
rtl/core/ianc_cell.sv
rtl/core/ianc_verdict.sv
rtl/core/id_and_account_number_checker.sv
tb/id_and_account_number_checker_tb.sv
